// ===== hw/rtl/rgb_to_lab_attenuated_assert.svh =====
// Assertion macros for the RGB to CIELAB pipeline.
`ifndef RGB_TO_LAB_ATTENUATED_ASSERT_SVH
`define RGB_TO_LAB_ATTENUATED_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define RLAB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rlab assertion failed");
// Next-cycle implication.
`define RLAB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rlab assertion failed");
`else
`define RLAB_ASSERT_IMP(label, clk, rst, ante, cons)
`define RLAB_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/rlab_pkg.sv =====
// Shared constants for the RGB to CIELAB pipeline.
package rlab_pkg;

  // Output fraction bits and internal Q21 format
  localparam int FRAC_BITS = 8;
  localparam int Q = 21;
  localparam logic [21:0] ONE = 22'd2097152;

  // Companding constants (Q21)
  localparam logic [21:0] THRESH = 22'd18572;
  localparam logic [21:0] OFFS_16_116 = 22'd289262;
  localparam logic [21:0] C06 = 22'd1258291;

  // RGB to XYZ matrix folded with the D65 white point
  localparam logic [12:0] COEF [3][3] = '{
    '{13'd3569, 13'd3094, 13'd1561},
    '{13'd1749, 13'd5882, 13'd594},
    '{13'd146,  13'd900,  13'd7178}
  };

  // Reciprocals for division by constants
  localparam logic [28:0] RECIP_1000 = 29'd274877907;  // ceil(2^38/1000)
  localparam logic [31:0] RECIP_10 = 32'd3435973837;   // ceil(2^35/10)
  localparam logic [27:0] RECIP_100 = 28'd171798692;   // ceil(2^34/100)
  // ceil(2^32/k), k = 1..8, for the exp Horner steps
  localparam logic [32:0] EXP_RECIP [1:8] = '{
    33'd4294967296, 33'd2147483648, 33'd1431655766, 33'd1073741824,
    33'd858993460,  33'd715827883,  33'd613566757,  33'd536870912
  };

  // Unit sizes
  localparam int CBRT_STAGES = 22;
  localparam int EXP_STEPS = 8;

  // Output rounding and saturation
  localparam int LR_SHIFT = Q - FRAC_BITS;
  localparam logic [28:0] LR_HALF = 29'(1) << (LR_SHIFT - 1);
  localparam int L_MAX_RAW = 100 << FRAC_BITS;
  localparam int L_SAT_I = (L_MAX_RAW > 32767) ? 32767 : L_MAX_RAW;
  localparam logic [14:0] L_SAT = 15'(L_SAT_I);
  localparam int CH_SHIFT = 2 * Q - FRAC_BITS;
  localparam logic [52:0] CH_HALF = 53'(1) << (CH_SHIFT - 1);

endpackage

// ===== hw/rtl/rlab_cbrt.sv =====
// Pipelined digit-by-digit cube root, one result bit per stage.
module rlab_cbrt import rlab_pkg::*; (
  input  logic                   clk,
  input  logic [CBRT_STAGES-1:0] en,
  input  logic [21:0]            v_in,
  output logic [21:0]            y_out,
  output logic [21:0]            v_out
);

  logic [21:0] y_q  [CBRT_STAGES];
  logic [43:0] sq_q [CBRT_STAGES];
  logic [49:0] r_q  [CBRT_STAGES];
  logic [21:0] v_q  [CBRT_STAGES];

  for (genvar j = 0; j < CBRT_STAGES; j++) begin : g_step
    logic [21:0] y_p;
    logic [43:0] sq_p;
    logic [49:0] r_p;
    logic [21:0] v_p;
    logic [23:0] vpad;
    logic [2:0]  grp;
    logic [49:0] r_sh;
    logic [49:0] sq_w;
    logic [49:0] y_w;
    logic [49:0] trial;

    if (j == 0) begin : g_first
      assign y_p = '0;
      assign sq_p = '0;
      assign r_p = '0;
      assign v_p = v_in;
    end else begin : g_next
      assign y_p = y_q[j-1];
      assign sq_p = sq_q[j-1];
      assign r_p = r_q[j-1];
      assign v_p = v_q[j-1];
    end

    // Radicand is v << 42: only the top eight digit groups are non-zero
    assign vpad = {2'b00, v_p};
    if (j < 8) begin : g_dig
      assign grp = vpad[23-3*j -: 3];
    end else begin : g_zero
      assign grp = 3'b000;
    end

    // (2y+1)^3 - (2y)^3 = 12y^2 + 6y + 1
    assign r_sh = {r_p[46:0], grp};
    assign sq_w = {6'b0, sq_p};
    assign y_w = {28'b0, y_p};
    assign trial = (sq_w << 3) + (sq_w << 2) + (y_w << 2) + (y_w << 1) + 50'd1;

    always_ff @(posedge clk) begin
      if (en[j]) begin
        v_q[j] <= v_p;
        if (r_sh >= trial) begin
          r_q[j] <= r_sh - trial;
          y_q[j] <= {y_p[20:0], 1'b1};
          sq_q[j] <= {sq_p[41:0], 2'b00} + {20'b0, y_p, 2'b00} + 44'd1;
        end else begin
          r_q[j] <= r_sh;
          y_q[j] <= {y_p[20:0], 1'b0};
          sq_q[j] <= {sq_p[41:0], 2'b00};
        end
      end
    end
  end

  assign y_out = y_q[CBRT_STAGES-1];
  assign v_out = v_q[CBRT_STAGES-1];

endmodule

// ===== hw/rtl/rlab_exp.sv =====
// Pipelined exp(-t) by Horner recurrence, two stages per term.
module rlab_exp import rlab_pkg::*; (
  input  logic                   clk,
  input  logic [2*EXP_STEPS-1:0] en,
  input  logic [21:0]            t_in,
  output logic [21:0]            w_out
);

  logic [21:0] t_q [2*EXP_STEPS];
  logic [21:0] m_q [EXP_STEPS];
  logic [21:0] p_q [EXP_STEPS];

  for (genvar i = 0; i < EXP_STEPS; i++) begin : g_term
    localparam int K = EXP_STEPS - i;
    logic [21:0] t_prev;
    logic [21:0] p_prev;
    logic [43:0] tp;
    logic [54:0] mq;

    if (i == 0) begin : g_first
      assign t_prev = t_in;
      assign p_prev = ONE;
    end else begin : g_next
      assign t_prev = t_q[2*i-1];
      assign p_prev = p_q[i-1];
    end

    // (t * p) >> 21
    assign tp = {22'b0, t_prev} * {22'b0, p_prev};

    always_ff @(posedge clk) begin
      if (en[2*i]) begin
        m_q[i] <= tp[42:21];
        t_q[2*i] <= t_prev;
      end
    end

    // p = ONE - m / K by reciprocal
    assign mq = {33'b0, m_q[i]} * {22'b0, EXP_RECIP[K]};

    always_ff @(posedge clk) begin
      if (en[2*i+1]) begin
        p_q[i] <= ONE - mq[53:32];
        t_q[2*i+1] <= t_q[2*i];
      end
    end
  end

  assign w_out = p_q[EXP_STEPS-1];

endmodule

// ===== hw/rtl/rgb_to_lab_attenuated.sv =====
// Top level: RGB to CIELAB (D65) pixel pipeline with chroma attenuation.
//
//  channel | direction | handshake           | payload
//  input   | in        | in_valid, in_stall   | red, green, blue, last_pixel
//  output  | out       | out_valid, out_stall | lightness, green_red, blue_yellow, last_out
//
// One pixel per clock sustained while out_stall is low; the path runs through the matrix stage,
// the 22-stage cube root, the 16-stage exp unit and companding, lightness and chroma stages.
// Synchronous reset clears only the valid bits; the data registers are not reset.
// Each stage holds while its successor is full and stalled, so bubbles close up and the
// input keeps flowing while a result waits at the output register, as long as a bubble remains.
`include "rgb_to_lab_attenuated_assert.svh"
module rgb_to_lab_attenuated import rlab_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  input  logic               last_pixel,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [14:0]        lightness,
  output logic signed [15:0] green_red,
  output logic signed [15:0] blue_yellow,
  output logic               last_out
);

  // Stage numbers
  localparam int ST_MAT = 0;
  localparam int ST_P1 = ST_MAT + CBRT_STAGES + 1;
  localparam int ST_P2 = ST_P1 + 1;
  localparam int ST_P3 = ST_P2 + 1;
  localparam int ST_P4 = ST_P3 + 1;
  localparam int ST_SQ = ST_P4 + 1;
  localparam int ST_T = ST_SQ + 1;
  localparam int ST_EXP = ST_T + 1;
  localparam int ST_C1 = ST_EXP + 2 * EXP_STEPS;
  localparam int ST_C2 = ST_C1 + 1;
  localparam int N_STG = ST_C2 + 1;

  logic [N_STG-1:0] vld;
  logic [N_STG-1:0] en;
  logic             last_d [N_STG];

  // Per-stage load enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[N_STG-1] = !vld[N_STG-1] || !out_stall;
    for (int i = N_STG - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_stall = !en[0];

  // Valid bits and last flag travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < N_STG; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) last_d[0] <= last_pixel;
    for (int i = 1; i < N_STG; i++) begin
      if (en[i]) last_d[i] <= last_d[i-1];
    end
  end

  // Matrix stage: X, Y, Z in Q21, clamped to one
  logic [7:0]  ch [3];
  logic [21:0] v_sum [3];
  logic [21:0] v0 [3];

  assign ch[0] = red;
  assign ch[1] = green;
  assign ch[2] = blue;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v_sum[i] = 22'(COEF[i][0]) * 22'(ch[0]) + 22'(COEF[i][1]) * 22'(ch[1])
               + 22'(COEF[i][2]) * 22'(ch[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_MAT]) begin
      for (int i = 0; i < 3; i++) begin
        v0[i] <= (v_sum[i] > ONE) ? ONE : v_sum[i];
      end
    end
  end

  // Cube roots
  logic [21:0] y_c [3];
  logic [21:0] v_c [3];

  for (genvar c = 0; c < 3; c++) begin : g_cbrt
    rlab_cbrt u_cbrt (
      .clk   (clk),
      .en    (en[ST_P1-1:ST_MAT+1]),
      .v_in  (v0[c]),
      .y_out (y_c[c]),
      .v_out (v_c[c])
    );
  end

  // P1: linear branch numerators and branch flags
  logic [27:0] xlin [3];
  logic [28:0] xl;
  logic        gt1 [3];
  logic [21:0] y1 [3];

  always_ff @(posedge clk) begin
    if (en[ST_P1]) begin
      for (int i = 0; i < 3; i++) begin
        xlin[i] <= 28'(v_c[i][14:0]) * 28'd7787 + 28'd500;
        gt1[i] <= v_c[i] > THRESH;
        y1[i] <= y_c[i];
      end
      xl <= 29'(v_c[1][14:0]) * 29'd9033 + 29'd5;
    end
  end

  // P2: divide by 1000 and 10 through reciprocals, pick the companding branch
  logic [56:0] qf_p [3];
  logic [60:0] ql_p;
  logic [21:0] f2 [3];
  logic [24:0] ql2;
  logic        gt2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qf_p[i] = {29'b0, xlin[i]} * {28'b0, RECIP_1000};
    end
    ql_p = {32'b0, xl} * {29'b0, RECIP_10};
  end

  always_ff @(posedge clk) begin
    if (en[ST_P2]) begin
      for (int i = 0; i < 3; i++) begin
        f2[i] <= gt1[i] ? y1[i] : (22'(qf_p[i][56:38]) + OFFS_16_116);
      end
      ql2 <= ql_p[59:35];
      gt2 <= gt1[1];
    end
  end

  // P3: L in Q21, a and b in Q21
  logic signed [22:0] da;
  logic signed [22:0] db;
  logic [27:0]        lq3;
  logic signed [31:0] a_d [ST_P3:ST_C1-1];
  logic signed [31:0] b_d [ST_P3:ST_C1-1];

  assign da = $signed({1'b0, f2[0]}) - $signed({1'b0, f2[1]});
  assign db = $signed({1'b0, f2[1]}) - $signed({1'b0, f2[2]});

  always_ff @(posedge clk) begin
    if (en[ST_P3]) begin
      lq3 <= gt2 ? ({6'b0, f2[1]} * 28'd116 - 28'd33554432) : 28'(ql2);
      a_d[ST_P3] <= 32'(da) * 32'sd500;
      b_d[ST_P3] <= 32'(db) * 32'sd200;
    end
    for (int i = ST_P3 + 1; i < ST_C1; i++) begin
      if (en[i]) begin
        a_d[i] <= a_d[i-1];
        b_d[i] <= b_d[i-1];
      end
    end
  end

  // P4: rounded, saturated lightness and L/100 for the weight
  logic [28:0] lr_sum;
  logic [28:0] lr;
  logic [55:0] lq_p;
  logic [21:0] lqd;
  logic [21:0] l4;
  logic [14:0] lt_d [ST_P4:ST_C2];

  assign lr_sum = {1'b0, lq3} + LR_HALF;
  assign lr = lr_sum >> LR_SHIFT;
  assign lq_p = {28'b0, lq3} * {28'b0, RECIP_100};
  assign lqd = lq_p[55:34];

  always_ff @(posedge clk) begin
    if (en[ST_P4]) begin
      lt_d[ST_P4] <= (lr > {14'b0, L_SAT}) ? L_SAT : lr[14:0];
      l4 <= (lqd > ONE) ? ONE : lqd;
    end
    for (int i = ST_P4 + 1; i <= ST_C2; i++) begin
      if (en[i]) lt_d[i] <= lt_d[i-1];
    end
  end

  // (L/100)^2
  logic [43:0] ll_p;
  logic [21:0] s5;

  assign ll_p = {22'b0, l4} * {22'b0, l4};

  always_ff @(posedge clk) begin
    if (en[ST_SQ]) s5 <= ll_p[42:21];
  end

  // t = 1.5 * (s - 0.6)^2, clamped to one
  logic signed [22:0] d6;
  logic [21:0]        dm;
  logic [43:0]        dd_p;
  logic [21:0]        u6;
  logic [23:0]        u3;
  logic [21:0]        t6;

  assign d6 = $signed({1'b0, s5}) - $signed({1'b0, C06});
  assign dm = d6[22] ? 22'(-d6) : 22'(d6);
  assign dd_p = {22'b0, dm} * {22'b0, dm};
  assign u6 = dd_p[42:21];
  assign u3 = {2'b0, u6} + {1'b0, u6, 1'b0};

  always_ff @(posedge clk) begin
    if (en[ST_T]) t6 <= (u3[23:1] > {1'b0, ONE}) ? ONE : u3[22:1];
  end

  // Weight exp(-t)
  logic [21:0] w;

  rlab_exp u_exp (
    .clk   (clk),
    .en    (en[ST_C1-1:ST_EXP]),
    .t_in  (t6),
    .w_out (w)
  );

  // C1: chroma magnitude times weight
  logic [29:0] mag_a;
  logic [29:0] mag_b;
  logic [51:0] pa;
  logic [51:0] pb;
  logic        na;
  logic        nb;

  assign mag_a = a_d[ST_C1-1][31] ? 30'(-a_d[ST_C1-1]) : 30'(a_d[ST_C1-1]);
  assign mag_b = b_d[ST_C1-1][31] ? 30'(-b_d[ST_C1-1]) : 30'(b_d[ST_C1-1]);

  always_ff @(posedge clk) begin
    if (en[ST_C1]) begin
      pa <= {22'b0, mag_a} * {30'b0, w};
      pb <= {22'b0, mag_b} * {30'b0, w};
      na <= a_d[ST_C1-1][31];
      nb <= b_d[ST_C1-1][31];
    end
  end

  // C2: round half away from zero, saturate to 16 bits
  function automatic logic [15:0] chroma_sat(input logic [51:0] p, input logic neg);
    logic [52:0] qv;
    logic [15:0] r;
    qv = ({1'b0, p} + CH_HALF) >> CH_SHIFT;
    if (neg) begin
      r = (qv > 53'd32768) ? 16'h8000 : (16'(~qv[15:0]) + 16'd1);
    end else begin
      r = (qv > 53'd32767) ? 16'h7fff : qv[15:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en[ST_C2]) begin
      green_red <= $signed(chroma_sat(pa, na));
      blue_yellow <= $signed(chroma_sat(pb, nb));
    end
  end

  assign lightness = lt_d[ST_C2];
  assign last_out = last_d[N_STG-1];
  assign out_valid = vld[N_STG-1];

  // Checks
  `RLAB_ASSERT_IMP(a_light_range, clk, rst, vld[N_STG-1], lightness <= L_SAT)
  `RLAB_ASSERT_IMP(a_stall_full, clk, rst, in_stall, vld[0])
  `RLAB_ASSERT_NXT(a_no_drop, clk, rst, vld[N_STG-1] && out_stall && vld[N_STG-2], vld[N_STG-2])

endmodule
